// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled during reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// File: rtl/prs_pkg.sv
package prs_pkg;

  localparam int TARGET_W = 20;
  localparam int BASE_W   = 17;
  localparam int ACH_W    = 23;
  localparam int ERR_W    = 26;

  localparam logic [BASE_W-1:0]   BASE_RESET   = 17'd50000;
  localparam logic [TARGET_W-1:0] SENTINEL_KHZ = 20'd1000000;

  typedef struct packed {
    logic [5:0] high;
    logic [4:0] low;
    logic       bypass;
    logic       odd;
  } cnt_enc_t;

  // pll counter phases: high = (x+1)/2, low = x - high
  function automatic cnt_enc_t encode_counter(input logic [7:0] x);
    logic [8:0] hi;
    cnt_enc_t   e;
    hi       = ({1'b0, x} + 9'd1) >> 1;
    e.high   = hi[5:0];
    e.low    = 5'(x - hi[7:0]);
    e.bypass = (x == 8'd1);
    e.odd    = x[0];
    return e;
  endfunction

endpackage

// File: rtl/pll_ratio_search.sv
// Finds the multiplier/divisor pair (1..MAX_RATIO each) whose output
// base_clock_khz*mul/div lies closest to target_khz; ties keep the pair met
// first with mul as the outer loop. The compare unit checks one pair per
// cycle, then a bit-serial divider produces achieved_khz one quotient bit
// per cycle. in_stall is high from acceptance until the result is loaded
// into the output register; a finished result waits there while the next
// request is taken. base_clock_khz is written through cfg_write/cfg_wdata
// and must only change while no request is in flight.
`include "assert_macros.svh"

module pll_ratio_search #(
  parameter int MAX_RATIO = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] target_khz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  best_mul,
  output logic [5:0]  best_div,
  output logic [22:0] achieved_khz,
  output logic [25:0] error_times_div,
  output logic [5:0]  div_high_count,
  output logic [4:0]  div_low_count,
  output logic        div_bypass,
  output logic        div_odd,
  output logic [5:0]  mul_high_count,
  output logic [4:0]  mul_low_count,
  output logic        mul_bypass,
  output logic        mul_odd
);

  localparam int RW  = $clog2(MAX_RATIO + 1);
  localparam int NW  = prs_pkg::TARGET_W + RW;
  localparam int PW  = prs_pkg::BASE_W + RW;
  localparam int CW  = $clog2(PW + 1);
  localparam int XW  = NW + RW;
  localparam int AEW = (PW > prs_pkg::ACH_W) ? PW : prs_pkg::ACH_W;
  localparam int EEW = (NW > prs_pkg::ERR_W) ? NW : prs_pkg::ERR_W;

  localparam logic [RW-1:0] RMAX = RW'(MAX_RATIO);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]  state;
  logic [16:0] base_clock_khz;
  logic [19:0] target;

  // candidate generator
  logic [RW-1:0] m, d;
  logic [NW-1:0] acc_b, acc_t;

  // registered candidate
  logic          valid_a;
  logic [RW-1:0] m_a, d_a;
  logic [NW-1:0] num_a, prod_a;

  // best so far
  logic [RW-1:0] bm, bd;
  logic [NW-1:0] best_num, best_err, best_prod;

  // divider
  logic [PW-1:0] q;
  logic [RW-1:0] rem;
  logic [CW-1:0] cnt;

  logic          in_acc;
  logic [NW-1:0] num_c;
  logic [19:0]   init_err;
  logic [XW-1:0] lhs, rhs;
  logic          better;
  logic [RW:0]   r_sh, r_diff;
  logic          r_ge;
  logic [AEW-1:0] q_ext;
  logic [EEW-1:0] e_ext;
  prs_pkg::cnt_enc_t enc_d, enc_m;
  logic          out_load;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign num_c = (acc_b >= acc_t) ? acc_b - acc_t : acc_t - acc_b;
  assign init_err = ({3'd0, base_clock_khz} >= target_khz) ?
                    {3'd0, base_clock_khz} - target_khz :
                    target_khz - {3'd0, base_clock_khz};

  // exact rational compare: num_a/d_a < best_num/bd
  assign lhs    = XW'(num_a) * XW'(bd);
  assign rhs    = XW'(best_num) * XW'(d_a);
  assign better = valid_a && (lhs < rhs);

  assign r_sh   = {rem, q[PW-1]};
  assign r_ge   = r_sh >= {1'b0, bd};
  assign r_diff = r_sh - {1'b0, bd};

  assign q_ext = AEW'(q);
  assign e_ext = EEW'(best_err);
  assign enc_d = prs_pkg::encode_counter(8'(bd));
  assign enc_m = prs_pkg::encode_counter(8'(bm));

  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_khz <= prs_pkg::BASE_RESET;
    end else if (cfg_write) begin
      base_clock_khz <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid_a <= 1'b0;
    end else begin
      valid_a <= (state == ST_SEARCH);
      unique case (state)
        ST_IDLE:   if (in_acc) state <= ST_SEARCH;
        ST_SEARCH: if (m == RMAX && d == RMAX) state <= ST_DRAIN;
        ST_DRAIN:  state <= ST_SETUP;
        ST_SETUP:  state <= ST_DIV;
        ST_DIV:    if (cnt == CW'(1)) state <= ST_FINISH;
        ST_FINISH: if (out_load) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // candidate generator: products kept by running sums
  always_ff @(posedge clk) begin
    if (in_acc) begin
      target <= target_khz;
      m      <= RW'(1);
      d      <= RW'(1);
      acc_b  <= NW'(base_clock_khz);
      acc_t  <= NW'(target_khz);
    end else if (state == ST_SEARCH) begin
      if (d == RMAX) begin
        d     <= RW'(1);
        acc_t <= NW'(target);
        m     <= m + RW'(1);
        acc_b <= acc_b + NW'(base_clock_khz);
      end else begin
        d     <= d + RW'(1);
        acc_t <= acc_t + NW'(target);
      end
    end
  end

  always_ff @(posedge clk) begin
    m_a    <= m;
    d_a    <= d;
    num_a  <= num_c;
    prod_a <= acc_b;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bm        <= RW'(1);
      bd        <= RW'(1);
      best_num  <= NW'(prs_pkg::SENTINEL_KHZ);
      best_err  <= NW'(init_err);
      best_prod <= NW'(base_clock_khz);
    end else if (better) begin
      bm        <= m_a;
      bd        <= d_a;
      best_num  <= num_a;
      best_err  <= num_a;
      best_prod <= prod_a;
    end
  end

  // restoring division of base*mul by div, msb first
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      q   <= best_prod[PW-1:0];
      rem <= '0;
      cnt <= CW'(PW);
    end else if (state == ST_DIV) begin
      q   <= {q[PW-2:0], r_ge};
      rem <= r_ge ? r_diff[RW-1:0] : r_sh[RW-1:0];
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_mul        <= 6'(bm);
      best_div        <= 6'(bd);
      achieved_khz    <= (q_ext > AEW'({prs_pkg::ACH_W{1'b1}})) ?
                         {prs_pkg::ACH_W{1'b1}} : q_ext[prs_pkg::ACH_W-1:0];
      error_times_div <= (e_ext > EEW'({prs_pkg::ERR_W{1'b1}})) ?
                         {prs_pkg::ERR_W{1'b1}} : e_ext[prs_pkg::ERR_W-1:0];
      div_high_count  <= enc_d.high;
      div_low_count   <= enc_d.low;
      div_bypass      <= enc_d.bypass;
      div_odd         <= enc_d.odd;
      mul_high_count  <= enc_m.high;
      mul_low_count   <= enc_m.low;
      mul_bypass      <= enc_m.bypass;
      mul_odd         <= enc_m.odd;
    end
  end

  `ASSERT_CLK(a_out_from_finish, clk, rst, $rose(out_valid) |-> $past(state) == ST_FINISH)
  `ASSERT_IMPLY(a_best_in_range, clk, rst, state != ST_IDLE, bd != '0 && bm != '0 && bd <= RMAX)
  `ASSERT_IMPLY(a_rem_below_div, clk, rst, state == ST_DIV, rem < bd)

endmodule

// File: sim/pll_ratio_search_tb.sv
module pll_ratio_search_tb;

  localparam int TARGET_W    = prs_pkg::TARGET_W;
  localparam int BASE_W      = prs_pkg::BASE_W;
  localparam int ACH_W       = prs_pkg::ACH_W;
  localparam int ERR_W       = prs_pkg::ERR_W;
  localparam int RATIO_LIMIT = 63;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [5:0]        mul;
    logic [5:0]        div;
    logic [ACH_W-1:0]  achieved;
    logic [ERR_W-1:0]  err;
    prs_pkg::cnt_enc_t div_enc;
    prs_pkg::cnt_enc_t mul_enc;
  } pll_setting_t;

  class ratio_scoreboard;
    logic [BASE_W-1:0] base_khz;
    pll_setting_t      expected[$];
    int                errors;
    int                checked;

    function new();
      base_khz = prs_pkg::BASE_RESET;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_base(logic [BASE_W-1:0] v);
      base_khz = v;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function longint unsigned clamp_bits(longint unsigned v, int w);
      longint unsigned lim;
      lim = (64'd1 << w) - 1;
      return (v > lim) ? lim : v;
    endfunction

    function prs_pkg::cnt_enc_t counter_fields(longint unsigned x);
      longint unsigned   hi;
      prs_pkg::cnt_enc_t e;
      hi       = (x + 1) / 2;
      e.high   = 6'(hi);
      e.low    = 5'(x - hi);
      e.bypass = (x == 1);
      e.odd    = 1'(x & 1);
      return e;
    endfunction

    // exhaustive search, errors compared as num/den by cross multiplication
    function pll_setting_t search_ratio(logic [TARGET_W-1:0] target);
      longint unsigned b, t, m, d, num, best_num, best_den, bm, bd;
      pll_setting_t    r;
      b        = base_khz;
      t        = target;
      bm       = 1;
      bd       = 1;
      best_num = prs_pkg::SENTINEL_KHZ;
      best_den = 1;
      for (m = 1; m <= RATIO_LIMIT; m++) begin
        for (d = 1; d <= RATIO_LIMIT; d++) begin
          num = (b * m >= t * d) ? b * m - t * d : t * d - b * m;
          if (num * best_den < best_num * d) begin
            bm       = m;
            bd       = d;
            best_num = num;
            best_den = d;
          end
        end
      end
      // error of the chosen pair, also when the sentinel was never beaten
      num        = (b * bm >= t * bd) ? b * bm - t * bd : t * bd - b * bm;
      r.mul      = 6'(bm);
      r.div      = 6'(bd);
      r.achieved = ACH_W'(clamp_bits((b * bm) / bd, ACH_W));
      r.err      = ERR_W'(clamp_bits(num, ERR_W));
      r.div_enc  = counter_fields(bd);
      r.mul_enc  = counter_fields(bm);
      return r;
    endfunction

    function void note_request(logic [TARGET_W-1:0] target);
      expected.push_back(search_ratio(target));
    endfunction

    function void check_field(string what, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(pll_setting_t got);
      pll_setting_t want;
      if (expected.size() == 0) begin
        $display("%0t: result with no request outstanding, mul %0d div %0d",
                 $time, got.mul, got.div);
        errors++;
        return;
      end
      want = expected.pop_front();
      checked++;
      check_field("best_mul", want.mul, got.mul);
      check_field("best_div", want.div, got.div);
      check_field("achieved_khz", want.achieved, got.achieved);
      check_field("error_times_div", want.err, got.err);
      check_field("div_high_count", want.div_enc.high, got.div_enc.high);
      check_field("div_low_count", want.div_enc.low, got.div_enc.low);
      check_field("div_bypass", want.div_enc.bypass, got.div_enc.bypass);
      check_field("div_odd", want.div_enc.odd, got.div_enc.odd);
      check_field("mul_high_count", want.mul_enc.high, got.mul_enc.high);
      check_field("mul_low_count", want.mul_enc.low, got.mul_enc.low);
      check_field("mul_bypass", want.mul_enc.bypass, got.mul_enc.bypass);
      check_field("mul_odd", want.mul_enc.odd, got.mul_enc.odd);
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                cfg_write  = 1'b0;
  logic [BASE_W-1:0]   cfg_wdata  = '0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [TARGET_W-1:0] target_khz = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [5:0]          best_mul;
  logic [5:0]          best_div;
  logic [ACH_W-1:0]    achieved_khz;
  logic [ERR_W-1:0]    error_times_div;
  logic [5:0]          div_high_count;
  logic [4:0]          div_low_count;
  logic                div_bypass;
  logic                div_odd;
  logic [5:0]          mul_high_count;
  logic [4:0]          mul_low_count;
  logic                mul_bypass;
  logic                mul_odd;

  ratio_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              settings      = 1;

  pll_ratio_search #(
    .MAX_RATIO(RATIO_LIMIT)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_khz     (target_khz),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .best_mul       (best_mul),
    .best_div       (best_div),
    .achieved_khz   (achieved_khz),
    .error_times_div(error_times_div),
    .div_high_count (div_high_count),
    .div_low_count  (div_low_count),
    .div_bypass     (div_bypass),
    .div_odd        (div_odd),
    .mul_high_count (mul_high_count),
    .mul_low_count  (mul_low_count),
    .mul_bypass     (mul_bypass),
    .mul_odd        (mul_odd)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    pll_setting_t got;
    if (!rst && out_valid && !out_stall) begin
      got.mul            = best_mul;
      got.div            = best_div;
      got.achieved       = achieved_khz;
      got.err            = error_times_div;
      got.div_enc.high   = div_high_count;
      got.div_enc.low    = div_low_count;
      got.div_enc.bypass = div_bypass;
      got.div_enc.odd    = div_odd;
      got.mul_enc.high   = mul_high_count;
      got.mul_enc.low    = mul_low_count;
      got.mul_enc.bypass = mul_bypass;
      got.mul_enc.odd    = mul_odd;
      sb.check_result(got);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, sb.pending());
    $display("pll_ratio_search_tb: done, errors");
    $finish;
  end

  // valid stays high after acceptance; the next call or an idle cycle changes it
  task automatic send_request(logic [TARGET_W-1:0] t);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    target_khz <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(t);
  endtask

  task automatic drain_results(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_base(v);
    settings++;
  endtask

  function automatic logic [TARGET_W-1:0] pick_target(logic [BASE_W-1:0] b);
    longint unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 1000000);
      4, 5, 6: begin
        // lands on or next to an exact ratio
        v = (longint'(b) * $urandom_range(1, RATIO_LIMIT)) / $urandom_range(1, RATIO_LIMIT);
        v = v + $urandom_range(0, 2) - 1;
        if (v > 20'hFFFFF) v = $urandom_range(0, 1000000);
      end
      7: v = $urandom() & 20'hFFFFF;
      8: v = $urandom_range(0, 1000);
      default: v = $urandom_range(1000000, 20'hFFFFF);
    endcase
    return TARGET_W'(v);
  endfunction

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 70;

    // reset base: field extremes, exact hits, and ties on equal ratios
    send_request(20'd0);
    send_request(20'd1);
    send_request(20'd25000);
    send_request(20'd50000);
    send_request(20'd100000);
    send_request(20'd148500);
    send_request(20'd74250);
    send_request(20'd1000000);
    send_request(20'hFFFFF);
    send_request(20'd524288);
    send_request(20'd12345);

    // tiny base: a full-scale target never beats the sentinel
    drain_results(8);
    write_base(17'd1);
    send_request(20'hFFFFF);
    send_request(20'd1000000);
    send_request(20'd63);

    // zero base: every pair ties at target zero
    drain_results(8);
    write_base(17'd0);
    send_request(20'd0);
    send_request(20'd999999);
    send_request(20'd1000000);

    drain_results(8);
    write_base(17'h1FFFF);
    send_request(20'hFFFFF);
    send_request(20'd0);

    drain_results(8);
    write_base(17'd100000);
    send_request(20'd1000000);
    send_request(20'd333333);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 18; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int h = 0; h < 2; h++) begin
        drain_results(8);
        write_base(($urandom_range(0, 4) == 0) ? BASE_W'(27000) :
                   BASE_W'($urandom_range(1, 100000)));
        repeat (22) send_request(pick_target(sb.base_khz));
      end
    end

    drain_results(4100);
    $display("checked %0d requests across %0d base clock settings", sb.checked, settings);
    $display("zero and full-scale base and target, sentinel fallback and ties included");
    if (sb.errors == 0)
      $display("pll_ratio_search_tb: done, clean");
    else
      $display("pll_ratio_search_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/prs_pkg.sv
rtl/pll_ratio_search.sv
sim/pll_ratio_search_tb.sv
